// File: sv/lkvc_pkg.sv
// Package: request/response types and constants of the LRU key/value cache.
`timescale 1ns / 1ps

package lkvc_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	// Capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Read value returned on a get miss and for every put
	localparam logic signed [DATA_W-1:0] READ_MISS = -32'sd1;

	typedef enum logic {
		MODE_GET = 1'b0,
		MODE_PUT = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t                    mode;
		logic signed [DATA_W-1:0] lookup_key;
		logic signed [DATA_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic                     key_hit;
		logic signed [DATA_W-1:0] read_value;
	} rsp_t;

endpackage

// File: sv/lru_key_value_cache_unit.sv
// LRU key/value cache: fully associative register store with recency ranks.
// Usage:
//   req channel (req_valid/req_ready/req) carries one get or put request.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one response per request,
//   in order: key_hit, and the stored value on a get hit (-1 otherwise).
//   cfg_we/cfg_wdata set the capacity (0 acts as 1, above ENTRIES as
//   ENTRIES); write it only while no request is in flight.
// Path: a request goes from the input register through one pass of key compare
//   and rank update into the response register. Throughput: one request per
//   cycle while the response is not held by a low rsp_ready; the key compare
//   across all entries and the parallel rank update are combinational.
// The least recent entry is the valid one whose rank equals occupancy-1.
// Reset: all entries invalid, ranks and occupancy zero, capacity 16; stored
//   keys and values are not cleared and need no clearing pass.
// Stall: when rsp_ready is low the response holds; one further request
//   can sit in the input register, after which req_ready drops.
`timescale 1ns / 1ps

module lru_key_value_cache_unit #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  lkvc_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output lkvc_pkg::rsp_t             rsp
);

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RANK_W = IDX_W;
	localparam int OCC_W  = $clog2(ENTRIES + 1);

	// Architectural state
	logic [KEY_BITS-1:0]   key_q   [ENTRIES];
	logic [VALUE_BITS-1:0] value_q [ENTRIES];
	logic [RANK_W-1:0]     rank_q  [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;
	logic [OCC_W-1:0]      occ_q;
	logic [lkvc_pkg::CAP_W-1:0] cap_q;

	// Input stage
	lkvc_pkg::req_t req_s1;
	logic           valid_s1;
	logic           advance;

	// Lookup results
	logic                  is_put;
	logic [KEY_BITS-1:0]   key_in;
	logic [VALUE_BITS-1:0] val_in;
	logic [OCC_W-1:0]      cap_eff;
	logic                  hit;
	logic [IDX_W-1:0]      hit_slot;
	logic                  free_found;
	logic [IDX_W-1:0]      free_slot;
	logic                  lru_found;
	logic [IDX_W-1:0]      lru_slot;
	logic [RANK_W-1:0]     lru_rank;
	logic [RANK_W-1:0]     hit_rank;
	logic                  ins;
	logic                  ins_new;
	logic [IDX_W-1:0]      ins_slot;
	logic [IDX_W-1:0]      tgt_slot;
	logic [ENTRIES-1:0]    age;
	lkvc_pkg::rsp_t        rsp_d;

	// Handshake: the input register moves on whenever the response slot frees
	assign advance   = valid_s1 && (!rsp_valid || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	// Field widening: keys and values sign extended from 32 bits, then trimmed
	always_comb begin
		logic [63:0] k64;
		logic [63:0] v64;
		k64    = {{32{req_s1.lookup_key[31]}}, req_s1.lookup_key};
		v64    = {{32{req_s1.write_value[31]}}, req_s1.write_value};
		key_in = k64[KEY_BITS-1:0];
		val_in = v64[VALUE_BITS-1:0];
		is_put = (req_s1.mode == lkvc_pkg::MODE_PUT);
	end

	// Capacity clamp to 1..ENTRIES
	always_comb begin
		int capi;
		capi = int'(cap_q);
		if (capi < 1) begin
			capi = 1;
		end
		if (capi > ENTRIES) begin
			capi = ENTRIES;
		end
		cap_eff = OCC_W'(capi);
	end

	// Key match, free slot and oldest entry (lowest index wins)
	always_comb begin
		lru_rank   = RANK_W'(occ_q - OCC_W'(1));
		hit        = 1'b0;
		hit_slot   = '0;
		free_found = 1'b0;
		free_slot  = '0;
		lru_found  = 1'b0;
		lru_slot   = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && key_q[i] == key_in) begin
				hit      = 1'b1;
				hit_slot = IDX_W'(i);
			end
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_slot  = IDX_W'(i);
			end
			if (valid_q[i] && rank_q[i] == lru_rank) begin
				lru_found = 1'b1;
				lru_slot  = IDX_W'(i);
			end
		end
	end

	// Replacement choice and recency update
	always_comb begin
		ins_new  = is_put && !hit && (occ_q < cap_eff) && free_found;
		ins      = ins_new || (is_put && !hit && !(occ_q < cap_eff) && lru_found);
		ins_slot = ins_new ? free_slot : lru_slot;
		tgt_slot = hit ? hit_slot : ins_slot;
		hit_rank = rank_q[hit_slot];
		for (int i = 0; i < ENTRIES; i++) begin
			age[i] = valid_q[i] && (IDX_W'(i) != tgt_slot) &&
			         (ins || rank_q[i] < hit_rank);
		end
	end

	// Response payload
	always_comb begin
		logic [63:0] r64;
		r64              = '0;
		r64[VALUE_BITS-1:0] = value_q[hit_slot];
		rsp_d.key_hit    = hit;
		rsp_d.read_value = (hit && !is_put) ? r64[31:0] : lkvc_pkg::READ_MISS;
	end

	// Control and recency state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			rsp_valid <= 1'b0;
			valid_q   <= '0;
			occ_q     <= '0;
			cap_q     <= lkvc_pkg::CAP_RESET;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			if (advance && (hit || ins)) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (age[i]) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end
				rank_q[tgt_slot] <= '0;
			end
			if (advance && ins) begin
				valid_q[ins_slot] <= 1'b1;
			end
			if (advance && ins_new) begin
				occ_q <= occ_q + OCC_W'(1);
			end
		end
	end

	// Payload registers and entry stores
	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp <= rsp_d;
			if (ins) begin
				key_q[ins_slot] <= key_in;
			end
			if (is_put && (hit || ins)) begin
				value_q[tgt_slot] <= val_in;
			end
		end
	end

`ifndef SYNTH
	// Occupancy tracks the number of valid entries
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("occupancy out of step with valid bits");

	// Occupancy never exceeds the store
	assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) <= ENTRIES)
		else $error("occupancy above entry count");

	// A request never enters while both stages are held
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rsp_valid && !rsp_ready) |-> !req_ready)
		else $error("request accepted while pipeline full");

	// A miss always reports the miss value
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.key_hit) |-> (rsp.read_value == lkvc_pkg::READ_MISS))
		else $error("miss response carries data");
`endif

endmodule
